>>> design/sjf_nonpreemptive_scheduler_core_macros.svh
// Assertion helpers for the scheduler RTL.
`ifndef SJF_NONPREEMPTIVE_SCHEDULER_CORE_MACROS_SVH
`define SJF_NONPREEMPTIVE_SCHEDULER_CORE_MACROS_SVH

// Same-cycle implication.
`define SJF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sjf scheduler assertion failed");

// Next-cycle implication.
`define SJF_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sjf scheduler assertion failed");

`endif

>>> design/sjf_pkg.sv
`timescale 1ns / 1ps

package sjf_pkg;

   localparam int TIME_BITS = 32;
   localparam int RES_BITS  = 3;

   localparam logic CMD_ARRIVE = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   typedef enum logic [RES_BITS-1:0] {
      EV_NONE     = 3'd0,
      EV_QUEUED   = 3'd1,
      EV_DROPPED  = 3'd2,
      EV_STARTED  = 3'd3,
      EV_FINISHED = 3'd4
   } event_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK,
      ST_POP,
      ST_WALK,
      ST_CMP,
      ST_ARR_RSP
   } state_type;

endpackage

>>> design/sjf_if.sv
`timescale 1ns / 1ps

interface sjf_req_if #(
   parameter int ID_BITS     = 8,
   parameter int LENGTH_BITS = 16
);
   logic                   valid;
   logic                   ready;
   logic                   cmd;
   logic [ID_BITS-1:0]     job_id;
   logic [LENGTH_BITS-1:0] job_duration;

   modport source (output valid, output cmd, output job_id, output job_duration,
                   input ready);
   modport sink   (input valid, input cmd, input job_id, input job_duration,
                   output ready);
endinterface

interface sjf_rsp_if #(
   parameter int ID_BITS     = 8,
   parameter int LENGTH_BITS = 16
);
   logic                            valid;
   logic                            ready;
   logic [sjf_pkg::RES_BITS-1:0]    event_res;
   logic [ID_BITS-1:0]              event_job;
   logic [LENGTH_BITS-1:0]          event_length;
   logic [sjf_pkg::TIME_BITS-1:0]   event_time;
   logic                            last;

   modport source (output valid, output event_res, output event_job,
                   output event_length, output event_time, output last,
                   input ready);
   modport sink   (input valid, input event_res, input event_job,
                   input event_length, input event_time, input last,
                   output ready);
endinterface

>>> design/sjf_ram.sv
`timescale 1ns / 1ps

module sjf_ram #(
   parameter int DEPTH  = 16,
   parameter int WIDTH  = 24,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

endmodule

>>> design/sjf_rsp_buf.sv
`timescale 1ns / 1ps

// Two-word result buffer between the sequencer and the result channel.
module sjf_rsp_buf #(
   parameter int WIDTH = 60
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   logic [WIDTH-1:0] buf_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full      = (cnt_ff == 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = buf_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         buf_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> design/sjf_ctrl.sv
`timescale 1ns / 1ps
`include "sjf_nonpreemptive_scheduler_core_macros.svh"

// Sequencer: the ready queue is a circular buffer in the RAM, kept sorted.
// Insert walks from the tail toward the head, one entry per read/write pair.
module sjf_ctrl #(
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_BITS     = 8,
   parameter int LENGTH_BITS = 16,
   parameter int PTR_W       = 4,
   parameter int OUT_W       = 60
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic                             in_cmd,
   input  logic [ID_BITS-1:0]               in_job_id,
   input  logic [LENGTH_BITS-1:0]           in_job_duration,
   output logic                             ram_we,
   output logic [PTR_W-1:0]                 ram_waddr,
   output logic [ID_BITS+LENGTH_BITS-1:0]   ram_wdata,
   output logic [PTR_W-1:0]                 ram_raddr,
   input  logic [ID_BITS+LENGTH_BITS-1:0]   ram_rdata,
   output logic                             push,
   output logic [OUT_W-1:0]                 push_data,
   input  logic                             full
);

   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W   = COUNT_W + 1;

   function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                 input logic [COUNT_W-1:0] off);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(off);
      if (sum >= SUM_W'(QUEUE_DEPTH)) begin
         sum = sum - SUM_W'(QUEUE_DEPTH);
      end
      return sum[PTR_W-1:0];
   endfunction

   sjf_pkg::state_type             state_ff, state_in;
   logic                           busy_ff, busy_in;
   logic [ID_BITS-1:0]             running_id_ff, running_id_in;
   logic [LENGTH_BITS-1:0]         remaining_ff, remaining_in;
   logic [sjf_pkg::TIME_BITS-1:0]  tick_ff, tick_in;
   logic [PTR_W-1:0]               head_ff, head_in;
   logic [COUNT_W-1:0]             count_ff, count_in;
   logic [ID_BITS-1:0]             id_ff, id_in;
   logic [LENGTH_BITS-1:0]         len_ff, len_in;
   logic [COUNT_W-1:0]             idx_ff, idx_in;
   logic                           drop_ff, drop_in;

   logic                           fin, start, need;
   logic [ID_BITS-1:0]             rd_id;
   logic [LENGTH_BITS-1:0]         rd_len;
   sjf_pkg::event_type             ev_res;
   logic [ID_BITS-1:0]             ev_job;
   logic [LENGTH_BITS-1:0]         ev_len;
   logic                           ev_last;

   assign rd_id     = ram_rdata[ID_BITS+LENGTH_BITS-1:LENGTH_BITS];
   assign rd_len    = ram_rdata[LENGTH_BITS-1:0];
   assign fin       = busy_ff && (remaining_ff == '0);
   assign start     = (!busy_ff || fin) && (count_ff != '0);
   assign need      = fin || !start;
   assign push_data = {ev_res, ev_job, ev_len, tick_ff, ev_last};

   always_comb begin
      state_in      = state_ff;
      busy_in       = busy_ff;
      running_id_in = running_id_ff;
      remaining_in  = remaining_ff;
      tick_in       = tick_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      id_in         = id_ff;
      len_in        = len_ff;
      idx_in        = idx_ff;
      drop_in       = drop_ff;
      in_ready      = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = head_ff;
      ram_wdata     = {id_ff, len_ff};
      ram_raddr     = head_ff;
      push          = 1'b0;
      ev_res        = sjf_pkg::EV_NONE;
      ev_job        = '0;
      ev_len        = '0;
      ev_last       = 1'b0;

      unique case (state_ff)
         sjf_pkg::ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               id_in  = in_job_id;
               // zero duration runs as one tick
               len_in = (in_job_duration == '0) ? LENGTH_BITS'(1) : in_job_duration;
               if (in_cmd == sjf_pkg::CMD_TICK) begin
                  state_in = sjf_pkg::ST_TICK;
               end else if (count_ff == COUNT_W'(QUEUE_DEPTH)) begin
                  drop_in  = 1'b1;
                  state_in = sjf_pkg::ST_ARR_RSP;
               end else begin
                  drop_in  = 1'b0;
                  idx_in   = count_ff;
                  state_in = sjf_pkg::ST_WALK;
               end
            end
         end
         sjf_pkg::ST_TICK: begin
            // head entry is being read here for a possible start
            if (!(need && full)) begin
               push = need;
               if (fin) begin
                  ev_res  = sjf_pkg::EV_FINISHED;
                  ev_job  = running_id_ff;
                  ev_last = !start;
                  busy_in = 1'b0;
               end else begin
                  ev_last = 1'b1;
               end
               if (start) begin
                  state_in = sjf_pkg::ST_POP;
               end else begin
                  if (busy_ff && !fin) begin
                     remaining_in = remaining_ff - LENGTH_BITS'(1);
                  end
                  tick_in  = tick_ff + 32'd1;
                  state_in = sjf_pkg::ST_IDLE;
               end
            end
         end
         sjf_pkg::ST_POP: begin
            if (!full) begin
               push          = 1'b1;
               ev_res        = sjf_pkg::EV_STARTED;
               ev_job        = rd_id;
               ev_len        = rd_len;
               ev_last       = 1'b1;
               running_id_in = rd_id;
               remaining_in  = rd_len - LENGTH_BITS'(1);
               busy_in       = 1'b1;
               head_in       = wrap_add(head_ff, COUNT_W'(1));
               count_in      = count_ff - COUNT_W'(1);
               tick_in       = tick_ff + 32'd1;
               state_in      = sjf_pkg::ST_IDLE;
            end
         end
         sjf_pkg::ST_WALK: begin
            if (idx_ff == '0) begin
               ram_we    = 1'b1;
               ram_waddr = head_ff;
               count_in  = count_ff + COUNT_W'(1);
               state_in  = sjf_pkg::ST_ARR_RSP;
            end else begin
               ram_raddr = wrap_add(head_ff, idx_ff - COUNT_W'(1));
               state_in  = sjf_pkg::ST_CMP;
            end
         end
         sjf_pkg::ST_CMP: begin
            ram_we    = 1'b1;
            ram_waddr = wrap_add(head_ff, idx_ff);
            // equal lengths stay ahead of the newcomer
            if (rd_len <= len_ff) begin
               count_in = count_ff + COUNT_W'(1);
               state_in = sjf_pkg::ST_ARR_RSP;
            end else begin
               ram_wdata = ram_rdata;
               idx_in    = idx_ff - COUNT_W'(1);
               state_in  = sjf_pkg::ST_WALK;
            end
         end
         sjf_pkg::ST_ARR_RSP: begin
            if (!full) begin
               push     = 1'b1;
               ev_res   = drop_ff ? sjf_pkg::EV_DROPPED : sjf_pkg::EV_QUEUED;
               ev_job   = id_ff;
               ev_len   = len_ff;
               ev_last  = 1'b1;
               state_in = sjf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sjf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sjf_pkg::ST_IDLE;
         busy_ff       <= 1'b0;
         running_id_ff <= '0;
         remaining_ff  <= '0;
         tick_ff       <= '0;
         head_ff       <= '0;
         count_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         busy_ff       <= busy_in;
         running_id_ff <= running_id_in;
         remaining_ff  <= remaining_in;
         tick_ff       <= tick_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff   <= id_in;
      len_ff  <= len_in;
      idx_ff  <= idx_in;
      drop_ff <= drop_in;
   end

   `SJF_ASSERT_IMP(a_count_range, clock, reset, 1'b1, count_ff <= COUNT_W'(QUEUE_DEPTH))
   `SJF_ASSERT_IMP(a_push_room, clock, reset, push, !full)
   `SJF_ASSERT_IMP(a_write_in_insert, clock, reset, ram_we,
                   (state_ff == sjf_pkg::ST_WALK) || (state_ff == sjf_pkg::ST_CMP))
   `SJF_ASSERT_NXT(a_start_runs, clock, reset, (state_ff == sjf_pkg::ST_POP) && !full,
                   busy_ff && (tick_ff == $past(tick_ff) + 32'd1))

endmodule

>>> design/sjf_nonpreemptive_scheduler_core.sv
`timescale 1ns / 1ps

// Non-preemptive shortest-job-first scheduler. The ready queue is a circular
// buffer in a single RAM (one write, one registered read per cycle) kept sorted
// by duration, equal durations in arrival order. An arrival's insert walks from
// the tail, one RAM read and one write-back per shifted entry, an entry being a
// queued job longer than the new one (at most QUEUE_DEPTH-1 of them). A dropped
// arrival only sends its result word; a tick that starts a job passes through a
// further pop state that takes the head entry off the queue. Each
// item gives one or two result words; a two-word result buffer lets the next
// item in while results wait, and an item stalls while that buffer is full.
// The queue RAM needs no clearing after reset.
module sjf_nonpreemptive_scheduler_core #(
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_BITS     = 8,
   parameter int LENGTH_BITS = 16
) (
   input logic       clock,
   input logic       reset,
   sjf_req_if.sink   req,
   sjf_rsp_if.source rsp
);

   localparam int PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int ENTRY_W = ID_BITS + LENGTH_BITS;
   localparam int OUT_W   = sjf_pkg::RES_BITS + ID_BITS + LENGTH_BITS
                            + sjf_pkg::TIME_BITS + 1;

   logic               ram_we;
   logic [PTR_W-1:0]   ram_waddr, ram_raddr;
   logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
   logic               push, full;
   logic [OUT_W-1:0]   push_data, out_data;

   sjf_ram #(
      .DEPTH  (QUEUE_DEPTH),
      .WIDTH  (ENTRY_W),
      .ADDR_W (PTR_W)
   ) u_ram (
      .clock    (clock),
      .we       (ram_we),
      .waddr    (ram_waddr),
      .wdata    (ram_wdata),
      .raddr    (ram_raddr),
      .rdata_ff (ram_rdata)
   );

   sjf_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ID_BITS     (ID_BITS),
      .LENGTH_BITS (LENGTH_BITS),
      .PTR_W       (PTR_W),
      .OUT_W       (OUT_W)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (req.valid),
      .in_ready        (req.ready),
      .in_cmd          (req.cmd),
      .in_job_id       (req.job_id),
      .in_job_duration (req.job_duration),
      .ram_we          (ram_we),
      .ram_waddr       (ram_waddr),
      .ram_wdata       (ram_wdata),
      .ram_raddr       (ram_raddr),
      .ram_rdata       (ram_rdata),
      .push            (push),
      .push_data       (push_data),
      .full            (full)
   );

   sjf_rsp_buf #(
      .WIDTH (OUT_W)
   ) u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_data  (out_data)
   );

   // word layout: res, job, length, time, last
   assign rsp.event_res    = out_data[OUT_W-1 -: sjf_pkg::RES_BITS];
   assign rsp.event_job    = out_data[OUT_W-1-sjf_pkg::RES_BITS -: ID_BITS];
   assign rsp.event_length = out_data[sjf_pkg::TIME_BITS+LENGTH_BITS : sjf_pkg::TIME_BITS+1];
   assign rsp.event_time   = out_data[sjf_pkg::TIME_BITS:1];
   assign rsp.last         = out_data[0];

endmodule

>>> test/tb_sjf_nonpreemptive_scheduler_core.sv
`timescale 1ns / 1ps

module tb_sjf_nonpreemptive_scheduler_core;

   localparam int QDEPTH        = 16;
   localparam int ID_W          = 8;
   localparam int LEN_W         = 16;
   localparam int DIRECTED_ROWS = 25;
   localparam int RANDOM_ITEMS  = 1280;
   localparam int LONG_TAIL     = 60;
   localparam int PAUSE_AT      = 640;
   localparam int HOLD_AFTER    = 300;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 60;
   localparam int DRAIN_LIMIT   = 50000;

   typedef struct packed {
      sjf_pkg::event_type            res;
      logic [ID_W-1:0]               job;
      logic [LEN_W-1:0]              len;
      logic [sjf_pkg::TIME_BITS-1:0] tstamp;
      logic                          last;
   } sched_event_type;

   typedef struct {
      logic             cmd;
      logic [ID_W-1:0]  id;
      logic [LEN_W-1:0] dur;
      bit               typed;
      sched_event_type  want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   sjf_req_if #(.ID_BITS(ID_W), .LENGTH_BITS(LEN_W)) req_bus ();
   sjf_rsp_if #(.ID_BITS(ID_W), .LENGTH_BITS(LEN_W)) rsp_bus ();

   sjf_nonpreemptive_scheduler_core #(
      .QUEUE_DEPTH(QDEPTH),
      .ID_BITS    (ID_W),
      .LENGTH_BITS(LEN_W)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req  (req_bus),
      .rsp  (rsp_bus)
   );

   always #5 clock = ~clock;

   // scheduler shadow state
   logic [ID_W-1:0]               wait_ids [$];
   logic [LEN_W-1:0]              wait_lens [$];
   bit                            cur_busy = 1'b0;
   logic [ID_W-1:0]               cur_id = '0;
   logic [LEN_W-1:0]              cur_left = '0;
   logic [sjf_pkg::TIME_BITS-1:0] tick_now = '0;

   sched_event_type step_events [$];
   sched_event_type due_events [$];
   sched_event_type oldest_due;

   stim_row_type     plan [DIRECTED_ROWS];
   logic [LEN_W-1:0] fill_lens [14] = '{16'd5, 16'd3, 16'd5, 16'd1, 16'd9, 16'd2, 16'd5,
                                        16'd3, 16'd7, 16'd1, 16'd4, 16'd8, 16'd2, 16'd6};

   int mismatch_count = 0;
   int items_sent = 0;
   int ticks_sent = 0;
   int words_seen = 0;
   int burst_left = 0;
   int quiet_n = 0, queued_n = 0, dropped_n = 0, started_n = 0, finished_n = 0;

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("%0t ns: mismatch, %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("word %0d %s got %0h want %0h",
                                   words_seen, name, got, want));
   endtask

   function automatic void note_event(input sjf_pkg::event_type res,
                                      input logic [ID_W-1:0] job,
                                      input logic [LEN_W-1:0] len);
      step_events.push_back('{res, job, len, tick_now, 1'b0});
   endfunction

   // Works out the result words one accepted word causes and updates the shadow state.
   function automatic void advance_schedule(input logic cmd, input logic [ID_W-1:0] id,
                                            input logic [LEN_W-1:0] dur);
      int               slot;
      logic [LEN_W-1:0] len;
      sched_event_type  tail_ev;
      step_events.delete();
      if (cmd == sjf_pkg::CMD_ARRIVE) begin
         len = (dur == '0) ? LEN_W'(1) : dur;
         if (wait_lens.size() < QDEPTH) begin
            // equal lengths go behind the ones already waiting
            slot = 0;
            while (slot < wait_lens.size() && wait_lens[slot] <= len) slot++;
            wait_ids.insert(slot, id);
            wait_lens.insert(slot, len);
            note_event(sjf_pkg::EV_QUEUED, id, len);
         end else begin
            note_event(sjf_pkg::EV_DROPPED, id, len);
         end
      end else begin
         if (cur_busy && cur_left == '0) begin
            note_event(sjf_pkg::EV_FINISHED, cur_id, '0);
            cur_busy = 1'b0;
         end
         if (!cur_busy && wait_ids.size() > 0) begin
            cur_id   = wait_ids.pop_front();
            cur_left = wait_lens.pop_front();
            cur_busy = 1'b1;
            note_event(sjf_pkg::EV_STARTED, cur_id, cur_left);
         end
         if (cur_busy && cur_left != '0) cur_left = cur_left - 1'b1;
         if (step_events.size() == 0) note_event(sjf_pkg::EV_NONE, '0, '0);
         tick_now = tick_now + 1'b1;
      end
      tail_ev = step_events.pop_back();
      tail_ev.last = 1'b1;
      step_events.push_back(tail_ev);
   endfunction

   task automatic pause_sender(input int cycles);
      @(negedge clock);
      req_bus.valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic issue(input stim_row_type r);
      @(negedge clock);
      req_bus.valid        <= 1'b1;
      req_bus.cmd          <= r.cmd;
      req_bus.job_id       <= r.id;
      req_bus.job_duration <= r.dur;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      advance_schedule(r.cmd, r.id, r.dur);
      if (r.typed) due_events.push_back(r.want);
      else foreach (step_events[i]) due_events.push_back(step_events[i]);
      items_sent++;
      if (r.cmd == sjf_pkg::CMD_TICK) ticks_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         pause_sender($urandom_range(1, 8));
         burst_left = $urandom_range(1, 30);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         words_seen++;
         case (rsp_bus.event_res)
            sjf_pkg::EV_NONE:     quiet_n++;
            sjf_pkg::EV_QUEUED:   queued_n++;
            sjf_pkg::EV_DROPPED:  dropped_n++;
            sjf_pkg::EV_STARTED:  started_n++;
            sjf_pkg::EV_FINISHED: finished_n++;
            default: ;
         endcase
         if (due_events.size() == 0) begin
            report_mismatch($sformatf("word %0d arrived with nothing expected",
                                      words_seen));
         end else begin
            oldest_due = due_events.pop_front();
            check_field("event_res", 32'(rsp_bus.event_res), 32'(oldest_due.res));
            check_field("event_job", 32'(rsp_bus.event_job), 32'(oldest_due.job));
            check_field("event_length", 32'(rsp_bus.event_length), 32'(oldest_due.len));
            check_field("event_time", rsp_bus.event_time, oldest_due.tstamp);
            check_field("last", 32'(rsp_bus.last), 32'(oldest_due.last));
         end
      end
   end

   // receiver: random stall modes, plus one long hold-off that backs the block up
   initial begin
      int mode;
      int mode_left;
      int hold_left;
      bit hold_done;
      mode = 0;
      mode_left = 0;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && words_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 80);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            case (mode)
               0:       rsp_bus.ready <= 1'b1;
               1:       rsp_bus.ready <= ($urandom_range(0, 3) != 0);
               default: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   initial begin
      #10_000_000;
      $display("run timed out with %0d words still expected", due_events.size());
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      stim_row_type row;
      bit           fill_phase;
      bit           tail;
      int           tick_pct;
      int           pick;
      int           guard;
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.cmd          = sjf_pkg::CMD_ARRIVE;
      req_bus.job_id       = '0;
      req_bus.job_duration = '0;
      fill_phase           = 1'b0;

      // quiet tick right after reset, then a zero length arrival
      plan[0] = '{sjf_pkg::CMD_TICK, 8'h00, 16'h0000, 1'b1,
                  '{sjf_pkg::EV_NONE, 8'h00, 16'h0000, 32'd0, 1'b1}};
      plan[1] = '{sjf_pkg::CMD_ARRIVE, 8'h00, 16'h0000, 1'b1,
                  '{sjf_pkg::EV_QUEUED, 8'h00, 16'h0001, 32'd1, 1'b1}};
      // fill the queue with ties on the way
      for (int k = 0; k < 14; k++)
         plan[2 + k] = '{sjf_pkg::CMD_ARRIVE, ID_W'(k * 37 + 3), fill_lens[k], 1'b0, '0};
      plan[16] = '{sjf_pkg::CMD_ARRIVE, 8'h80, 16'h0003, 1'b0, '0};
      // queue full: both get dropped
      plan[17] = '{sjf_pkg::CMD_ARRIVE, 8'hFF, 16'hFFFF, 1'b1,
                   '{sjf_pkg::EV_DROPPED, 8'hFF, 16'hFFFF, 32'd1, 1'b1}};
      plan[18] = '{sjf_pkg::CMD_ARRIVE, 8'h01, 16'h0001, 1'b1,
                   '{sjf_pkg::EV_DROPPED, 8'h01, 16'h0001, 32'd1, 1'b1}};
      // start, then finish plus start on one tick
      for (int k = 19; k < 24; k++)
         plan[k] = '{sjf_pkg::CMD_TICK, ID_W'(k), LEN_W'(k), 1'b0, '0};
      plan[24] = '{sjf_pkg::CMD_ARRIVE, 8'h5A, 16'h0000, 1'b0, '0};

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      burst_left = $urandom_range(1, 30);

      for (int k = 0; k < DIRECTED_ROWS; k++) issue(plan[k]);

      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k % 120 == 0) fill_phase = ($urandom_range(0, 1) == 1);
         // long jobs only near the end so they never block the middle of the run
         tail     = (k >= RANDOM_ITEMS - LONG_TAIL);
         tick_pct = tail ? 30 : (fill_phase ? 35 : 80);
         row.typed = 1'b0;
         row.want  = '0;
         row.cmd   = ($urandom_range(0, 99) < tick_pct) ? sjf_pkg::CMD_TICK
                                                        : sjf_pkg::CMD_ARRIVE;
         row.id    = ID_W'($urandom);
         pick      = $urandom_range(0, 99);
         if (tail || row.cmd == sjf_pkg::CMD_TICK) row.dur = LEN_W'($urandom);
         else if (pick < 5)                        row.dur = '0;
         else if (pick < 90)                       row.dur = LEN_W'($urandom_range(1, 6));
         else                                      row.dur = LEN_W'($urandom_range(7, 15));
         if (k == PAUSE_AT) begin
            pause_sender(1);
            while (due_events.size() != 0) @(negedge clock);
         end
         issue(row);
      end

      @(negedge clock);
      req_bus.valid <= 1'b0;
      guard = 0;
      while (due_events.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      foreach (due_events[i])
         report_mismatch($sformatf("expected word never arrived: event %0d job %0h time %0d",
                                   due_events[i].res, due_events[i].job,
                                   due_events[i].tstamp));
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("sent %0d words (%0d ticks), checked %0d result words",
               items_sent, ticks_sent, words_seen);
      $display("queued %0d, dropped %0d, started %0d, finished %0d, quiet ticks %0d",
               queued_n, dropped_n, started_n, finished_n, quiet_n);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
